// File: sv/avcc_to_annexb_nal_converter_unit_macros.svh
// Assertion macros for the AVCC to Annex B converter.
`ifndef AVCC_TO_ANNEXB_NAL_CONVERTER_UNIT_MACROS_SVH
`define AVCC_TO_ANNEXB_NAL_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define A2B_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("a2b assertion failed");

// Next-cycle implication, held off during reset.
`define A2B_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("a2b assertion failed");

`else

`define A2B_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define A2B_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: sv/a2b_pkg.sv
`default_nettype none

package a2b_pkg;

    localparam int MAX_PACKET_BYTES = 16777216;
    localparam int REM_W            = $clog2(MAX_PACKET_BYTES);
    localparam int ACC_W            = 32;
    localparam int CNT_W            = 3;
    localparam int CFG_W            = 3;
    localparam int BYTE_W           = 8;
    localparam int STATUS_W         = 2;

    // Command queue between front and back (power of two depth)
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W-1:0] NAL_LEN_RESET = 3'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DATA         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERRUN      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT_PREFIX = 2'd2;

    localparam int START_CODE_LEN = 4;
    localparam int SC_IDX_W       = $clog2(START_CODE_LEN);
    localparam logic [SC_IDX_W-1:0] SC_IDX_LAST = SC_IDX_W'(START_CODE_LEN - 1);
    localparam logic [BYTE_W-1:0] START_CODE [START_CODE_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

    typedef enum logic [1:0] {
        CMD_DATA   = 2'd0,
        CMD_STATUS = 2'd1,
        CMD_START  = 2'd2
    } cmd_kind_t;

    // flag: nal_end for data bytes, zero-length NAL for start codes
    typedef struct packed {
        cmd_kind_t             kind;
        logic [BYTE_W-1:0]     data;
        logic                  flag;
        logic [STATUS_W-1:0]   status;
    } cmd_t;

    // Prefix widths outside 2..4 fall back to one byte
    function automatic logic [CFG_W-1:0] prefix_width(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] w;
        w = (v >= 3'd2 && v <= 3'd4) ? v : 3'd1;
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/a2b_cmd_fifo.sv
`default_nettype none

module a2b_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire a2b_pkg::cmd_t cmd_in,
    output logic               full,
    input  wire logic          pop,
    output a2b_pkg::cmd_t      cmd_out,
    output logic               empty
);
    import a2b_pkg::*;

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// File: sv/a2b_front.sv
`default_nettype none

module a2b_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [a2b_pkg::CFG_W-1:0]  nal_length_bytes,
    input  wire logic                       in_accept,
    input  wire logic [a2b_pkg::BYTE_W-1:0] in_byte,
    input  wire logic [a2b_pkg::REM_W-1:0]  bytes_after,
    output logic                            cmd_push,
    output a2b_pkg::cmd_t                   cmd
);
    import a2b_pkg::*;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]   left_reg, left_next;

    logic               final_byte;
    logic [CFG_W-1:0]   width;
    logic [ACC_W-1:0]   acc_shift;
    logic [CNT_W-1:0]   cnt_inc;
    logic [REM_W-1:0]   left_dec;
    logic               overrun;
    logic               nal_done;

    assign final_byte = (bytes_after == '0);
    assign width      = prefix_width(nal_length_bytes);
    assign acc_shift  = {acc_reg[ACC_W-BYTE_W-1:0], in_byte};
    assign cnt_inc    = cnt_reg + 1'b1;
    assign left_dec   = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
    assign overrun    = (acc_shift[ACC_W-1:REM_W] != '0) || (acc_shift[REM_W-1:0] > bytes_after);
    assign nal_done   = (left_dec == '0) || final_byte;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        cmd_push   = 1'b0;
        cmd        = '{kind: CMD_DATA, data: in_byte, flag: 1'b0, status: STATUS_DATA};

        if (in_accept) begin
            unique case (phase_reg)
                PH_DROP: begin
                    if (final_byte) begin
                        phase_next = PH_PREFIX;
                        cnt_next   = '0;
                        acc_next   = '0;
                        left_next  = '0;
                    end
                end
                PH_PAYLOAD: begin
                    cmd_push  = 1'b1;
                    cmd.flag  = nal_done;
                    left_next = left_dec;
                    if (nal_done) begin
                        phase_next = PH_PREFIX;
                        cnt_next   = '0;
                        acc_next   = '0;
                        left_next  = '0;
                    end
                end
                default: begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (cnt_inc < width) begin
                        if (final_byte) begin
                            cmd_push   = 1'b1;
                            cmd.kind   = CMD_STATUS;
                            cmd.status = STATUS_SHORT_PREFIX;
                            phase_next = PH_PREFIX;
                            cnt_next   = '0;
                            acc_next   = '0;
                            left_next  = '0;
                        end
                    end else if (overrun) begin
                        cmd_push   = 1'b1;
                        cmd.kind   = CMD_STATUS;
                        cmd.status = STATUS_OVERRUN;
                        phase_next = final_byte ? PH_PREFIX : PH_DROP;
                        cnt_next   = '0;
                        acc_next   = '0;
                        left_next  = '0;
                    end else begin
                        cmd_push  = 1'b1;
                        cmd.kind  = CMD_START;
                        cmd.flag  = (acc_shift == '0);
                        cnt_next  = '0;
                        acc_next  = '0;
                        if ((acc_shift == '0) || final_byte) begin
                            phase_next = PH_PREFIX;
                            left_next  = '0;
                        end else begin
                            phase_next = PH_PAYLOAD;
                            left_next  = acc_shift[REM_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/a2b_back.sv
`default_nettype none

module a2b_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cmd_valid,
    input  wire a2b_pkg::cmd_t                cmd,
    output logic                              cmd_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [a2b_pkg::BYTE_W-1:0]        m_out_byte,
    output logic [a2b_pkg::STATUS_W-1:0]      m_status,
    output logic                              m_nal_end,
    output logic                              m_run_last
);
    import a2b_pkg::*;

    logic                  m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]     m_out_byte_reg, m_out_byte_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic                  m_nal_end_reg, m_nal_end_next;
    logic                  m_run_last_reg, m_run_last_next;
    logic [SC_IDX_W-1:0]   sc_idx_reg, sc_idx_next;
    logic                  load;
    logic                  sc_last;

    // Output register is free when empty or being drained this cycle
    assign load    = cmd_valid && (!m_valid_reg || m_ready);
    assign sc_last = (sc_idx_reg == SC_IDX_LAST);

    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_out_byte_next = m_out_byte_reg;
        m_status_next   = m_status_reg;
        m_nal_end_next  = m_nal_end_reg;
        m_run_last_next = m_run_last_reg;
        sc_idx_next     = sc_idx_reg;
        cmd_pop         = 1'b0;

        if (load) begin
            unique case (cmd.kind)
                CMD_START: begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = START_CODE[sc_idx_reg];
                    m_status_next   = STATUS_DATA;
                    m_nal_end_next  = sc_last && cmd.flag;
                    m_run_last_next = sc_last;
                    cmd_pop         = sc_last;
                    sc_idx_next     = sc_last ? '0 : sc_idx_reg + 1'b1;
                end
                CMD_DATA: begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = cmd.data;
                    m_status_next   = STATUS_DATA;
                    m_nal_end_next  = cmd.flag;
                    m_run_last_next = 1'b1;
                    cmd_pop         = 1'b1;
                end
                CMD_STATUS: begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = '0;
                    m_status_next   = cmd.status;
                    m_nal_end_next  = 1'b0;
                    m_run_last_next = 1'b1;
                    cmd_pop         = 1'b1;
                end
                default: begin
                    cmd_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sc_idx_reg  <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            sc_idx_reg  <= sc_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_out_byte_reg <= m_out_byte_next;
        m_status_reg   <= m_status_next;
        m_nal_end_reg  <= m_nal_end_next;
        m_run_last_reg <= m_run_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_status   = m_status_reg;
    assign m_nal_end  = m_nal_end_reg;
    assign m_run_last = m_run_last_reg;

endmodule

`default_nettype wire

// File: sv/avcc_to_annexb_nal_converter_unit.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_valid / s_ready    s_in_byte[7:0], s_bytes_after[23:0]
// m_        out  m_valid / m_ready    m_out_byte[7:0], m_status[1:0], m_nal_end, m_run_last
// cfg_      in   cfg_valid/cfg_ready  cfg_nal_length_bytes[2:0]
//
// Payload and prefix bytes: one transfer per cycle in while the queue has room, one per
// cycle out while m_ready is high. Completed prefix: four output transfers (start code),
// so the input stalls while they drain once the two-entry command queue fills.
// Reset (aresetn low, synchronous): prefix phase, empty queue, prefix width one byte.
// Either side may stall independently; the queue decouples front from back.
`default_nettype none

module avcc_to_annexb_nal_converter_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input byte channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [a2b_pkg::BYTE_W-1:0]     s_in_byte,
    input  wire logic [a2b_pkg::REM_W-1:0]      s_bytes_after,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [a2b_pkg::BYTE_W-1:0]          m_out_byte,
    output logic [a2b_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_nal_end,
    output logic                                m_run_last,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [a2b_pkg::CFG_W-1:0]      cfg_nal_length_bytes
);
    import a2b_pkg::*;

`include "avcc_to_annexb_nal_converter_unit_macros.svh"

    logic [CFG_W-1:0] nal_length_bytes_reg, nal_length_bytes_next;

    logic   s_accept;
    logic   cmd_push;
    cmd_t   cmd_in;
    cmd_t   cmd_head;
    logic   fifo_full;
    logic   fifo_empty;
    logic   cmd_pop;

    // The user must write config only while idle; the block itself does not enforce it and is always ready.
    assign cfg_ready = 1'b1;

    always_comb begin
        nal_length_bytes_next = nal_length_bytes_reg;
        if (cfg_valid && cfg_ready) begin
            nal_length_bytes_next = cfg_nal_length_bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nal_length_bytes_reg <= NAL_LEN_RESET;
        end else begin
            nal_length_bytes_reg <= nal_length_bytes_next;
        end
    end

    // Every input byte produces at most one command, so queue space is enough
    assign s_ready  = !fifo_full;
    assign s_accept = s_valid && s_ready;

    // Front: prefix gathering, length check, payload count
    a2b_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .nal_length_bytes (nal_length_bytes_reg),
        .in_accept        (s_accept),
        .in_byte          (s_in_byte),
        .bytes_after      (s_bytes_after),
        .cmd_push         (cmd_push),
        .cmd              (cmd_in)
    );

    a2b_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .cmd_in  (cmd_in),
        .full    (fifo_full),
        .pop     (cmd_pop),
        .cmd_out (cmd_head),
        .empty   (fifo_empty)
    );

    // Back: expands start codes, drives the output register
    a2b_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (!fifo_empty),
        .cmd        (cmd_head),
        .cmd_pop    (cmd_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_status   (m_status),
        .m_nal_end  (m_nal_end),
        .m_run_last (m_run_last)
    );

    // Status transfers are lone results with a zero byte
    `A2B_ASSERT_IMP(a_status_shape, aclk, aresetn,
        m_valid && (m_status != STATUS_DATA),
        m_run_last && !m_nal_end && (m_out_byte == '0))

    // NAL end always closes the run of one input byte
    `A2B_ASSERT_IMP(a_end_is_last, aclk, aresetn, m_valid && m_nal_end, m_run_last)

    // No output appears without a queued command
    `A2B_ASSERT_NXT(a_no_phantom, aclk, aresetn, !m_valid && fifo_empty, !m_valid)

endmodule

`default_nettype wire
